[design/trtcp_pkg.sv]
// Package for the two-rate three-color policer: register indexes, colors and the prefix mask.
`timescale 1ns / 1ps
`default_nettype none
package trtcp_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_COMMITTED_RATE     = 3'd0;
   localparam csr_index_type CSR_COMMITTED_BURST    = 3'd1;
   localparam csr_index_type CSR_EXCESS_RATE        = 3'd2;
   localparam csr_index_type CSR_EXCESS_BURST       = 3'd3;
   localparam csr_index_type CSR_SUBSCRIBER_ADDRESS = 3'd4;

   typedef enum logic [1:0] {
      COLOR_GREEN  = 2'd0,
      COLOR_YELLOW = 2'd1,
      COLOR_RED    = 2'd2
   } color_type;

   localparam logic [31:0] PREFIX_MASK = 32'hffff_ff00;

endpackage
`default_nettype wire

[design/trtcp_bucket.sv]
// Token bucket refill: tokens plus rate times elapsed seconds, saturated at the burst size when refill is enabled.
`timescale 1ns / 1ps
`default_nettype none
module trtcp_bucket (
   input  wire logic [31:0] tokens,
   input  wire logic [31:0] rate,
   input  wire logic [31:0] elapsed,
   input  wire logic [31:0] burst,
   input  wire logic        refill_enable,
   output logic      [31:0] refilled
);

   logic [63:0] product;
   logic [63:0] sum;

   // 64 bits hold the worst case: (2^32-1)^2 + 2^32-1 < 2^64
   assign product = {32'd0, rate} * {32'd0, elapsed};
   assign sum     = product + {32'd0, tokens};

   always_comb begin
      if (!refill_enable) begin
         // no elapsed time: a fill above a lowered burst is kept
         refilled = tokens;
      end else if (sum > {32'd0, burst}) begin
         refilled = burst;
      end else begin
         refilled = sum[31:0];
      end
   end

endmodule
`default_nettype wire

[design/two_rate_three_color_policer_top.sv]
// Top level of the color-blind two-rate three-color policer for one subscriber.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    packet_size, now_seconds, source_address
//   rsp      out        rsp_valid/ready    matched, color, subscriber_prefix
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// One item per cycle sustained while rsp_ready stays high. An item waits in the input register;
// the refill multiply, clamp, color compare and debit are done combinationally while it is there,
// against the bucket state, which is updated as the item moves into the result register.
// A full result register with rsp_ready low stalls the input register, which then holds req_ready low.
// Synchronous reset clears the valids, the configuration and the bucket state.
`timescale 1ns / 1ps
`default_nettype none
module two_rate_three_color_policer_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [15:0]                   req_packet_size,
   input  wire logic [31:0]                   req_now_seconds,
   input  wire logic [31:0]                   req_source_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_matched,
   output logic [1:0]                         rsp_color,
   output logic [31:0]                        rsp_subscriber_prefix,
   input  wire logic                          csr_write_enable,
   input  wire trtcp_pkg::csr_index_type      csr_index,
   input  wire logic [31:0]                   csr_write_data
);
   import trtcp_pkg::*;

   // configuration
   logic [31:0] committed_rate_ff, committed_burst_ff;
   logic [31:0] excess_rate_ff, excess_burst_ff;
   logic [31:0] subscriber_address_ff;

   // bucket state
   logic [31:0] committed_tokens_ff, committed_tokens_in;
   logic [31:0] excess_tokens_ff, excess_tokens_in;
   logic [31:0] last_refill_second_ff, last_refill_second_in;

   // input register
   logic        stage_valid_ff;
   logic [15:0] stage_size_ff;
   logic [31:0] stage_now_ff;
   logic [31:0] stage_source_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_matched_ff, rsp_matched_in;
   color_type   rsp_color_ff, rsp_color_in;
   logic [31:0] rsp_prefix_ff, rsp_prefix_in;

   logic        advance;
   logic        accept;
   logic [31:0] prefix;
   logic        hit;
   logic [31:0] elapsed;
   logic        refill_enable;
   logic [31:0] committed_refilled;
   logic [31:0] excess_refilled;
   logic [31:0] size_wide;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign prefix        = subscriber_address_ff & PREFIX_MASK;
   assign hit           = (stage_source_ff & PREFIX_MASK) == prefix;
   assign elapsed       = stage_now_ff - last_refill_second_ff;
   assign refill_enable = elapsed != 32'd0;
   assign size_wide     = {16'd0, stage_size_ff};

   trtcp_bucket u_committed (
      .tokens        (committed_tokens_ff),
      .rate          (committed_rate_ff),
      .elapsed       (elapsed),
      .burst         (committed_burst_ff),
      .refill_enable (refill_enable),
      .refilled      (committed_refilled)
   );

   trtcp_bucket u_excess (
      .tokens        (excess_tokens_ff),
      .rate          (excess_rate_ff),
      .elapsed       (elapsed),
      .burst         (excess_burst_ff),
      .refill_enable (refill_enable),
      .refilled      (excess_refilled)
   );

   always_comb begin
      committed_tokens_in   = committed_tokens_ff;
      excess_tokens_in      = excess_tokens_ff;
      last_refill_second_in = last_refill_second_ff;
      rsp_matched_in        = 1'b0;
      rsp_color_in          = COLOR_GREEN;
      rsp_prefix_in         = 32'd0;
      if (hit) begin
         rsp_matched_in        = 1'b1;
         rsp_prefix_in         = prefix;
         committed_tokens_in   = committed_refilled;
         excess_tokens_in      = excess_refilled;
         if (refill_enable) begin
            last_refill_second_in = stage_now_ff;
         end
         if (size_wide <= committed_refilled) begin
            committed_tokens_in = committed_refilled - size_wide;
            rsp_color_in        = COLOR_GREEN;
         end else if (size_wide <= excess_refilled) begin
            excess_tokens_in = excess_refilled - size_wide;
            rsp_color_in     = COLOR_YELLOW;
         end else begin
            rsp_color_in = COLOR_RED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_rate_ff     <= 32'd0;
         committed_burst_ff    <= 32'd0;
         excess_rate_ff        <= 32'd0;
         excess_burst_ff       <= 32'd0;
         subscriber_address_ff <= 32'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COMMITTED_RATE:     committed_rate_ff     <= csr_write_data;
            CSR_COMMITTED_BURST:    committed_burst_ff    <= csr_write_data;
            CSR_EXCESS_RATE:        excess_rate_ff        <= csr_write_data;
            CSR_EXCESS_BURST:       excess_burst_ff       <= csr_write_data;
            CSR_SUBSCRIBER_ADDRESS: subscriber_address_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_tokens_ff   <= 32'd0;
         excess_tokens_ff      <= 32'd0;
         last_refill_second_ff <= 32'd0;
      end else if (advance) begin
         committed_tokens_ff   <= committed_tokens_in;
         excess_tokens_ff      <= excess_tokens_in;
         last_refill_second_ff <= last_refill_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_size_ff   <= req_packet_size;
         stage_now_ff    <= req_now_seconds;
         stage_source_ff <= req_source_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_matched_ff <= rsp_matched_in;
         rsp_color_ff   <= rsp_color_in;
         rsp_prefix_ff  <= rsp_prefix_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_matched           = rsp_matched_ff;
   assign rsp_color             = rsp_color_ff;
   assign rsp_subscriber_prefix = rsp_prefix_ff;

endmodule
`default_nettype wire
